// File: rtl/core/ppt_pkg.sv
// Shared constants, types and reset contents for the pin permission table.
package ppt_pkg;

  localparam int MAX_ENTRIES   = 16;
  localparam int IDX_W         = $clog2(MAX_ENTRIES);
  localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);
  localparam int PIN_W         = 8;
  localparam int ENTRY_W       = 5;
  localparam int DEFAULT_COUNT = 5;

  localparam logic [PIN_W-1:0] DEFAULT_PINS [DEFAULT_COUNT] =
    '{8'd10, 8'd11, 8'd12, 8'd14, 8'd15};

  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_ALLOW = 2'd1,
    OP_DENY  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNLISTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_DENIED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_SET_LEVEL = 2'd0,
    ACT_GET_LEVEL = 2'd1,
    ACT_SET_DIR   = 2'd2,
    ACT_OTHER     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_MOVE = 2'd2
  } state_t;

  // Write request from the sequencer to the table store.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [PIN_W-1:0] wdata;
    logic             cnt_inc;
    logic             cnt_dec;
  } wr_req_t;

endpackage

// File: rtl/core/ppt_store.sv
// Pin table registers and listed-entry count with one read and one write port.
module ppt_store (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [ppt_pkg::IDX_W-1:0]       rd_addr,
  output logic [ppt_pkg::PIN_W-1:0]       rd_data,
  input  ppt_pkg::wr_req_t                wr_req,
  output logic [ppt_pkg::CNT_W-1:0]       count
);
  import ppt_pkg::*;

  logic [PIN_W-1:0] table_r [MAX_ENTRIES];
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEFAULT_COUNT; i++) begin
        table_r[i] <= DEFAULT_PINS[i];
      end
      for (int i = DEFAULT_COUNT; i < MAX_ENTRIES; i++) begin
        table_r[i] <= '0;
      end
    end else if (wr_req.we) begin
      table_r[wr_req.waddr] <= wr_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(DEFAULT_COUNT);
    end else if (wr_req.cnt_inc) begin
      count_r <= count_r + CNT_W'(1);
    end else if (wr_req.cnt_dec) begin
      count_r <= count_r - CNT_W'(1);
    end
  end

  assign rd_data = table_r[rd_addr];
  assign count   = count_r;

endmodule

// File: rtl/core/ppt_ctrl.sv
// Request sequencer: linear scan with a shared pin comparator, then the update step.
module ppt_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [1:0]                      op,
  input  logic [ppt_pkg::PIN_W-1:0]       pin,
  input  logic [1:0]                      action,
  input  logic [ppt_pkg::PIN_W-1:0]       rd_data,
  input  logic [ppt_pkg::CNT_W-1:0]       count,
  output logic                            busy,
  output logic [ppt_pkg::IDX_W-1:0]       rd_addr,
  output ppt_pkg::wr_req_t                wr_req,
  output logic                            done,
  output ppt_pkg::status_t                status
);
  import ppt_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  op_t              op_r;
  logic [PIN_W-1:0] pin_r;
  action_t          act_r;

  logic             accept;
  logic             scan_end;
  logic             hit;
  logic [CNT_W-1:0] last_idx;

  assign accept   = start && (state_r == S_IDLE);
  assign scan_end = (idx_r >= count);
  assign hit      = !scan_end && (rd_data == pin_r);
  assign last_idx = count - CNT_W'(1);
  assign busy     = (state_r != S_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
          idx_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (hit) begin
          pos_nxt   = idx_r[IDX_W-1:0];
          state_nxt = (op_r == OP_DENY) ? S_MOVE : S_IDLE;
        end else if (scan_end) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_MOVE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    rd_addr = idx_r[IDX_W-1:0];
    wr_req  = '0;
    done    = 1'b0;
    status  = ST_OK;
    unique case (state_r)
      S_IDLE: begin
      end
      S_SCAN: begin
        if (hit) begin
          done = (op_r != OP_DENY);
          if (op_r == OP_CHECK && act_r == ACT_OTHER) status = ST_DENIED;
        end else if (scan_end) begin
          done = 1'b1;
          unique case (op_r)
            OP_ALLOW: begin
              if (count >= CNT_W'(MAX_ENTRIES)) begin
                status = ST_FULL;
              end else begin
                wr_req.we      = 1'b1;
                wr_req.waddr   = count[IDX_W-1:0];
                wr_req.wdata   = pin_r;
                wr_req.cnt_inc = 1'b1;
              end
            end
            OP_CHECK, OP_DENY, OP_QUERY: status = ST_UNLISTED;
            default: status = ST_UNLISTED;
          endcase
        end
      end
      S_MOVE: begin
        // Fill the hole with the last entry and shrink the list.
        rd_addr        = last_idx[IDX_W-1:0];
        wr_req.we      = 1'b1;
        wr_req.waddr   = pos_r;
        wr_req.wdata   = rd_data;
        wr_req.cnt_dec = 1'b1;
        done           = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(op);
      pin_r <= pin;
      act_r <= action_t'(action);
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_SCAN)
    else $error("accepted request did not enter scan");
  a_move_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOVE |-> $past(state_r == S_SCAN) && $past(op_r == OP_DENY))
    else $error("move step not preceded by a deny hit");
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> state_r == S_IDLE)
    else $error("sequencer did not return to idle after completion");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("listed count exceeds table size");
`endif

endmodule

// File: rtl/core/pin_permission_table.sv
// Top level of the pin permission table: ports, sequencer, table store and result register.
//
// Keeps an unordered whitelist of up to MAX_ENTRIES pin numbers (16 here)
// and answers one request per transfer: check, allow (insert), deny (remove,
// the last entry fills the hole) or membership query. After reset the list
// holds pins 10, 11, 12, 14 and 15. A request is taken when start is high
// and busy is low; busy then stays high while the sequencer scans the list
// one entry per cycle through a single shared pin comparator. It stops at
// the first match or after the last listed entry; a successful deny then
// adds a move step that copies the last entry into the hole. The result
// appears on out_status and out_entry_count, marked by out_valid high for
// exactly one cycle; the receiver cannot stall it, so capture it on that
// cycle. out_entry_count is the number of listed pins after the request,
// low five bits. A new request may start in the cycle the result is
// shown.
module pin_permission_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_operation,
  input  logic [ppt_pkg::PIN_W-1:0]         in_pin,
  input  logic [1:0]                        in_action_code,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [ppt_pkg::ENTRY_W-1:0]       out_entry_count
);
  import ppt_pkg::*;

  logic [IDX_W-1:0] rd_addr;
  logic [PIN_W-1:0] rd_data;
  logic [CNT_W-1:0] count;
  wr_req_t          wr_req;
  logic             done;
  status_t          status;

  logic             out_valid_r;
  status_t          out_status_r;

  // Sequencer: scan, compare, decide the update
  ppt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .op      (in_operation),
    .pin     (in_pin),
    .action  (in_action_code),
    .rd_data (rd_data),
    .count   (count),
    .busy    (busy),
    .rd_addr (rd_addr),
    .wr_req  (wr_req),
    .done    (done),
    .status  (status)
  );

  // Table contents and listed count
  ppt_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_req  (wr_req),
    .count   (count)
  );

  // Register the result strobe and status; the count register has already taken
  // its new value at the same edge and cannot move again before the next
  // request finishes its scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_status_r <= status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = ENTRY_W'(count);

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the pin permission table: directed and random requests.
`timescale 1ns / 1ps

module testbench;
  import ppt_pkg::*;

  // Run limits: idle gaps are short, so a thousand-odd transfers fit well
  // inside this budget.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int REPORT_LIMIT  = 100;
  localparam int RANDOM_ITEMS  = 1030;
  localparam int PHASE_LEN     = 75;
  localparam int POOL_SIZE     = 20;
  localparam int IDLE_PERCENT  = 35;
  localparam int BURST_FIRST   = 300;
  localparam int BURST_LAST    = 500;

  typedef struct {
    op_t              op;
    logic [PIN_W-1:0] pin;
    action_t          action;
  } pin_req_t;

  typedef struct {
    status_t            status;
    logic [ENTRY_W-1:0] count;
  } answer_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          in_operation = '0;
  logic [PIN_W-1:0]    in_pin = '0;
  logic [1:0]          in_action_code = '0;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [ENTRY_W-1:0]  out_entry_count;

  // Requests waiting to be driven, answers waiting to be seen.
  pin_req_t  pending_reqs[$];
  answer_t   due_answers[$];

  // Shadow copy of the whitelist, updated in transfer order.
  logic [PIN_W-1:0] shadow_pins[MAX_ENTRIES];
  int               shadow_count;

  logic [PIN_W-1:0] pin_pool[POOL_SIZE];
  logic             took;
  int               sent_count = 0;
  int               err_count = 0;
  int               cycle_count = 0;

  pin_permission_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_pin          (in_pin),
    .in_action_code  (in_action_code),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one request to the shadow list and return the answer it earns.
  // The pin lookup comes first, so an unlisted pin wins over a bad action.
  function automatic answer_t apply_request(pin_req_t r);
    answer_t a;
    int      pos;
    pos = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (pos < 0 && shadow_pins[i] == r.pin) pos = i;
    end
    a.status = ST_OK;
    case (r.op)
      OP_CHECK: begin
        if (pos < 0) a.status = ST_UNLISTED;
        else if (r.action == ACT_OTHER) a.status = ST_DENIED;
      end
      OP_ALLOW: begin
        // a pin already listed is a quiet success
        if (pos < 0) begin
          if (shadow_count >= MAX_ENTRIES) begin
            a.status = ST_FULL;
          end else begin
            shadow_pins[shadow_count] = r.pin;
            shadow_count++;
          end
        end
      end
      OP_DENY: begin
        // fill the hole with the last entry
        if (pos < 0) begin
          a.status = ST_UNLISTED;
        end else begin
          shadow_count--;
          shadow_pins[pos] = shadow_pins[shadow_count];
        end
      end
      default: begin
        if (pos < 0) a.status = ST_UNLISTED;
      end
    endcase
    a.count = ENTRY_W'(shadow_count);
    return a;
  endfunction

  function automatic void queue_req(op_t op, int pin, action_t action);
    pin_req_t r;
    r.op     = op;
    r.pin    = PIN_W'(pin);
    r.action = action;
    pending_reqs.push_back(r);
  endfunction

  // Driver: change inputs on the falling edge. Drop the request on the ports
  // once the last rising edge took it, then either present the next one or
  // idle with junk on the payload. Start is assigned once per edge, so
  // back-to-back transfers keep it high without a glitch.
  always @(negedge clk) begin
    logic go;
    if (rst_n) begin
      if (took && pending_reqs.size() > 0) begin
        void'(pending_reqs.pop_front());
        sent_count++;
      end
      go = pending_reqs.size() > 0 &&
           ((sent_count >= BURST_FIRST && sent_count < BURST_LAST) ||
            $urandom_range(99) >= IDLE_PERCENT);
      if (go) begin
        start          <= 1'b1;
        in_operation   <= pending_reqs[0].op;
        in_pin         <= pending_reqs[0].pin;
        in_action_code <= pending_reqs[0].action;
      end else begin
        start          <= 1'b0;
        in_operation   <= 2'($urandom);
        in_pin         <= PIN_W'($urandom);
        in_action_code <= 2'($urandom);
      end
    end
  end

  // Monitor: sample on the rising edge. Check any result strobe against the
  // oldest answer due, then predict the answer for a transfer taken now.
  always @(posedge clk) begin
    pin_req_t r;
    answer_t  want;
    if (!rst_n) begin
      took <= 1'b0;
    end else begin
      if (out_valid) begin
        if (due_answers.size() == 0) begin
          err_count++;
          if (err_count <= REPORT_LIMIT)
            $error("result strobe with no request outstanding: status %0d, entry_count %0d",
                   out_status, out_entry_count);
        end else begin
          want = due_answers.pop_front();
          if (out_status !== want.status) begin
            err_count++;
            if (err_count <= REPORT_LIMIT)
              $error("status: expected %0d, got %0d", want.status, out_status);
          end
          if (out_entry_count !== want.count) begin
            err_count++;
            if (err_count <= REPORT_LIMIT)
              $error("entry_count: expected %0d, got %0d", want.count, out_entry_count);
          end
        end
      end
      took <= start && !busy;
      if (start && !busy) begin
        r.op     = op_t'(in_operation);
        r.pin    = in_pin;
        r.action = action_t'(in_action_code);
        due_answers.push_back(apply_request(r));
      end
    end
  end

  // Watchdog: give up if the run hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int      phase;
    int      roll;
    int      pin;
    op_t     op;
    bit      filling;

    for (int i = 0; i < DEFAULT_COUNT; i++) shadow_pins[i] = DEFAULT_PINS[i];
    for (int i = DEFAULT_COUNT; i < MAX_ENTRIES; i++) shadow_pins[i] = '0;
    shadow_count = DEFAULT_COUNT;

    // Directed part: every operation against the fallback list, action
    // codes at both ends, the unlisted pin beating a bad action, duplicate
    // allow, removal from the front with the last entry moving up, then
    // fill the table and push one more allow into it.
    queue_req(OP_CHECK, 10,  ACT_SET_LEVEL);
    queue_req(OP_CHECK, 15,  ACT_GET_LEVEL);
    queue_req(OP_CHECK, 12,  ACT_SET_DIR);
    queue_req(OP_CHECK, 14,  ACT_OTHER);
    queue_req(OP_CHECK, 13,  ACT_OTHER);
    queue_req(OP_CHECK, 255, ACT_SET_LEVEL);
    queue_req(OP_QUERY, 11,  ACT_OTHER);
    queue_req(OP_QUERY, 0,   ACT_SET_LEVEL);
    queue_req(OP_ALLOW, 10,  ACT_SET_DIR);
    queue_req(OP_ALLOW, 255, ACT_OTHER);
    queue_req(OP_DENY,  10,  ACT_OTHER);
    queue_req(OP_DENY,  77,  ACT_SET_LEVEL);
    queue_req(OP_ALLOW, 0,   ACT_GET_LEVEL);
    for (int i = 0; i < 10; i++) queue_req(OP_ALLOW, 100 + 13 * i, action_t'(i % 4));
    queue_req(OP_ALLOW, 254, ACT_SET_LEVEL);

    // A small pool of pins makes hits frequent; the fallback pins and both
    // ends of the range are always in it.
    foreach (pin_pool[i]) pin_pool[i] = PIN_W'($urandom);
    pin_pool[0] = 8'd10;
    pin_pool[1] = 8'd11;
    pin_pool[2] = 8'd12;
    pin_pool[3] = 8'd14;
    pin_pool[4] = 8'd15;
    pin_pool[5] = 8'd0;
    pin_pool[6] = 8'd255;

    // Random part: alternate fill-heavy and drain-heavy phases so the
    // table swings between full and empty; a fifth of the pins come from
    // the whole range.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase   = n / PHASE_LEN;
      filling = (phase % 2) == 0;
      roll    = $urandom_range(99);
      if (roll < 60)      op = filling ? OP_ALLOW : OP_DENY;
      else if (roll < 70) op = filling ? OP_DENY : OP_ALLOW;
      else if (roll < 85) op = OP_CHECK;
      else                op = OP_QUERY;
      if ($urandom_range(99) < 20) pin = $urandom_range(255);
      else                         pin = pin_pool[$urandom_range(POOL_SIZE - 1)];
      queue_req(op, pin, action_t'($urandom_range(3)));
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Hold until every request is taken and every answer seen, then give
    // a stray strobe time to show up.
    while (pending_reqs.size() != 0 || due_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (due_answers.size() != 0) begin
      err_count++;
      $error("%0d answers never arrived", due_answers.size());
    end
    if (err_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
